// ===== rtl/nearest_downscale_quantize_unit_assert.svh =====
// Assertion macros used by the checker file of the downscale quantize unit.
`ifndef NEAREST_DOWNSCALE_QUANTIZE_UNIT_ASSERT_SVH
`define NEAREST_DOWNSCALE_QUANTIZE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ndq_pkg.sv =====
// Shared types, constants and helpers of the downscale quantize unit.
`timescale 1ns / 1ps

package ndq_pkg;

    localparam int LUMA_W      = 8;
    localparam int VALUE_W     = 8;
    localparam int COORD_W     = 7;
    localparam int DIM_CFG_W   = 12;
    localparam int GAIN_W      = 24;
    localparam int ZP_W        = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam int OUT_WIDTH_DEF      = 96;
    localparam int OUT_HEIGHT_DEF     = 96;
    localparam int MAX_SOURCE_DIM_DEF = 2048;

    localparam int WIDTH_RST  = 320;
    localparam int HEIGHT_RST = 240;
    localparam int GAIN_RST   = 32768;
    localparam int ZP_RST     = 0;

    typedef logic [LUMA_W-1:0]         luma_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic signed [ZP_W-1:0]    zp_t;
    typedef logic [CFG_INDEX_W-1:0]    cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

    localparam cfg_index_t REG_SOURCE_WIDTH  = cfg_index_t'(0);
    localparam cfg_index_t REG_SOURCE_HEIGHT = cfg_index_t'(1);
    localparam cfg_index_t REG_PIXEL_GAIN    = cfg_index_t'(2);
    localparam cfg_index_t REG_QUANT_OFFSET  = cfg_index_t'(3);

    // Result of the coordinate match for the pixel in the input register.
    typedef struct packed {
        logic   emit;
        logic   last;
        coord_t column;
        coord_t line;
    } coord_hit_t;

    function automatic int clamp_dim(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ndq_if.sv =====
// Channel interfaces: pixel input, result output and configuration write.
`timescale 1ns / 1ps

interface ndq_pixel_if;
    logic          valid;
    logic          ready;
    ndq_pkg::luma_t luma;
    logic          frame_start;

    modport source (output valid, luma, frame_start, input ready);
    modport sink (input valid, luma, frame_start, output ready);
endinterface

interface ndq_result_if;
    logic            valid;
    logic            ready;
    ndq_pkg::value_t pixel_value;
    ndq_pkg::coord_t out_column;
    ndq_pkg::coord_t out_line;
    logic            frame_last;

    modport source (output valid, pixel_value, out_column, out_line, frame_last, input ready);
    modport sink (input valid, pixel_value, out_column, out_line, frame_last, output ready);
endinterface

interface ndq_cfg_if;
    logic                valid;
    logic                ready;
    ndq_pkg::cfg_index_t index;
    ndq_pkg::cfg_data_t  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ndq_const_div.sv =====
// Division of a narrow unsigned value by a constant: reciprocal multiply plus one correction.
`timescale 1ns / 1ps

module ndq_const_div #(
    parameter int DIVISOR = 96,
    parameter int IN_W    = 12
) (
    input  logic [IN_W-1:0]             x,
    output logic [IN_W-1:0]             quot,
    output logic [$clog2(DIVISOR)-1:0]  rem
);

    localparam int REM_W = $clog2(DIVISOR);
    localparam int SHIFT = IN_W;
    localparam logic [IN_W-1:0] RECIP = IN_W'((2 ** SHIFT) / DIVISOR);

    logic [2*IN_W-1:0] prod;
    logic [2*IN_W-1:0] back;
    logic [IN_W-1:0]   q_est;
    logic [IN_W-1:0]   rem_full;
    logic [IN_W-1:0]   rem_fix;
    logic              corr;

    // Estimate is exact or one short, since x stays below 2^SHIFT.
    assign prod     = (2*IN_W)'(x) * (2*IN_W)'(RECIP);
    assign q_est    = prod[2*IN_W-1:IN_W];
    assign back     = (2*IN_W)'(q_est) * (2*IN_W)'(DIVISOR);
    assign rem_full = x - back[IN_W-1:0];
    assign corr     = rem_full >= IN_W'(DIVISOR);
    assign rem_fix  = corr ? (rem_full - IN_W'(DIVISOR)) : rem_full;
    assign quot     = corr ? (q_est + IN_W'(1)) : q_est;
    assign rem      = rem_fix[REM_W-1:0];

endmodule

// ===== rtl/ndq_cfg_regs.sv =====
// Configuration registers with clamped source sizes held as quotient and remainder.
`timescale 1ns / 1ps

module ndq_cfg_regs #(
    parameter int OUT_WIDTH      = ndq_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT     = ndq_pkg::OUT_HEIGHT_DEF,
    parameter int MAX_SOURCE_DIM = ndq_pkg::MAX_SOURCE_DIM_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    ndq_cfg_if.sink                                cfg,
    output logic [$clog2(MAX_SOURCE_DIM+1)-1:0]    src_w,
    output logic [$clog2(MAX_SOURCE_DIM+1)-1:0]    w_quot,
    output logic [$clog2(OUT_WIDTH)-1:0]           w_rem,
    output logic [$clog2(MAX_SOURCE_DIM+1)-1:0]    h_quot,
    output logic [$clog2(OUT_HEIGHT)-1:0]          h_rem,
    output ndq_pkg::gain_t                         gain,
    output ndq_pkg::zp_t                           quant_offset
);

    localparam int DIM_W = $clog2(MAX_SOURCE_DIM + 1);
    localparam int CMP_W = (DIM_W > ndq_pkg::DIM_CFG_W) ? DIM_W : ndq_pkg::DIM_CFG_W;
    localparam int CRW   = $clog2(OUT_WIDTH);
    localparam int RRW   = $clog2(OUT_HEIGHT);

    localparam int W_RST = ndq_pkg::clamp_dim(ndq_pkg::WIDTH_RST, OUT_WIDTH, MAX_SOURCE_DIM);
    localparam int H_RST = ndq_pkg::clamp_dim(ndq_pkg::HEIGHT_RST, OUT_HEIGHT, MAX_SOURCE_DIM);

    logic [CMP_W-1:0] wr_dim;
    logic [CMP_W-1:0] w_clamp;
    logic [CMP_W-1:0] h_clamp;
    logic [DIM_W-1:0] w_new;
    logic [DIM_W-1:0] h_new;
    logic [DIM_W-1:0] w_new_quot;
    logic [DIM_W-1:0] h_new_quot;
    logic [CRW-1:0]   w_new_rem;
    logic [RRW-1:0]   h_new_rem;
    logic             wr_en;

    logic [DIM_W-1:0]  src_w_reg;
    logic [DIM_W-1:0]  w_quot_reg;
    logic [CRW-1:0]    w_rem_reg;
    logic [DIM_W-1:0]  h_quot_reg;
    logic [RRW-1:0]    h_rem_reg;
    ndq_pkg::gain_t    gain_reg;
    ndq_pkg::zp_t      quant_offset_reg;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign wr_dim    = CMP_W'(cfg.data[ndq_pkg::DIM_CFG_W-1:0]);

    always_comb
    begin
        if (wr_dim < CMP_W'(OUT_WIDTH))
        begin
            w_clamp = CMP_W'(OUT_WIDTH);
        end
        else if (wr_dim > CMP_W'(MAX_SOURCE_DIM))
        begin
            w_clamp = CMP_W'(MAX_SOURCE_DIM);
        end
        else
        begin
            w_clamp = wr_dim;
        end

        if (wr_dim < CMP_W'(OUT_HEIGHT))
        begin
            h_clamp = CMP_W'(OUT_HEIGHT);
        end
        else if (wr_dim > CMP_W'(MAX_SOURCE_DIM))
        begin
            h_clamp = CMP_W'(MAX_SOURCE_DIM);
        end
        else
        begin
            h_clamp = wr_dim;
        end
    end

    assign w_new = DIM_W'(w_clamp);
    assign h_new = DIM_W'(h_clamp);

    ndq_const_div #(
        .DIVISOR (OUT_WIDTH),
        .IN_W    (DIM_W)
    ) u_w_div (
        .x    (w_new),
        .quot (w_new_quot),
        .rem  (w_new_rem)
    );

    ndq_const_div #(
        .DIVISOR (OUT_HEIGHT),
        .IN_W    (DIM_W)
    ) u_h_div (
        .x    (h_new),
        .quot (h_new_quot),
        .rem  (h_new_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg        <= DIM_W'(W_RST);
            w_quot_reg       <= DIM_W'(W_RST / OUT_WIDTH);
            w_rem_reg        <= CRW'(W_RST % OUT_WIDTH);
            h_quot_reg       <= DIM_W'(H_RST / OUT_HEIGHT);
            h_rem_reg        <= RRW'(H_RST % OUT_HEIGHT);
            gain_reg         <= ndq_pkg::gain_t'(ndq_pkg::GAIN_RST);
            quant_offset_reg <= ndq_pkg::zp_t'(ndq_pkg::ZP_RST);
        end
        else if (wr_en)
        begin
            case (cfg.index)
                ndq_pkg::REG_SOURCE_WIDTH:
                begin
                    src_w_reg  <= w_new;
                    w_quot_reg <= w_new_quot;
                    w_rem_reg  <= w_new_rem;
                end
                ndq_pkg::REG_SOURCE_HEIGHT:
                begin
                    h_quot_reg <= h_new_quot;
                    h_rem_reg  <= h_new_rem;
                end
                ndq_pkg::REG_PIXEL_GAIN:
                begin
                    gain_reg <= cfg.data[ndq_pkg::GAIN_W-1:0];
                end
                ndq_pkg::REG_QUANT_OFFSET:
                begin
                    quant_offset_reg <= ndq_pkg::zp_t'(cfg.data[ndq_pkg::ZP_W-1:0]);
                end
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign src_w        = src_w_reg;
    assign w_quot       = w_quot_reg;
    assign w_rem        = w_rem_reg;
    assign h_quot       = h_quot_reg;
    assign h_rem        = h_rem_reg;
    assign gain         = gain_reg;
    assign quant_offset = quant_offset_reg;

endmodule

// ===== rtl/ndq_scan.sv =====
// Source and output coordinate tracking; flags source pixels that land on the output grid.
`timescale 1ns / 1ps

module ndq_scan #(
    parameter int OUT_WIDTH      = ndq_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT     = ndq_pkg::OUT_HEIGHT_DEF,
    parameter int MAX_SOURCE_DIM = ndq_pkg::MAX_SOURCE_DIM_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   frame_start,
    input  logic [$clog2(MAX_SOURCE_DIM+1)-1:0]    src_w,
    input  logic [$clog2(MAX_SOURCE_DIM+1)-1:0]    w_quot,
    input  logic [$clog2(OUT_WIDTH)-1:0]           w_rem,
    input  logic [$clog2(MAX_SOURCE_DIM+1)-1:0]    h_quot,
    input  logic [$clog2(OUT_HEIGHT)-1:0]          h_rem,
    output ndq_pkg::coord_hit_t                    hit
);

    localparam int DIM_W = $clog2(MAX_SOURCE_DIM + 1);
    localparam int CNT_W = $clog2(MAX_SOURCE_DIM);
    localparam int OCW   = $clog2(OUT_WIDTH);
    localparam int ORW   = $clog2(OUT_HEIGHT + 1);
    localparam int CRW   = $clog2(OUT_WIDTH);
    localparam int RRW   = $clog2(OUT_HEIGHT);

    logic [CNT_W-1:0] src_col_reg, src_col_next, e_src_col;
    logic [CNT_W-1:0] src_row_reg, src_row_next, e_src_row;
    logic [OCW-1:0]   ocol_reg, ocol_next, e_ocol;
    logic [ORW-1:0]   orow_reg, orow_next, e_orow;
    logic [DIM_W-1:0] cq_reg, cq_next, e_cq;
    logic [CRW-1:0]   cr_reg, cr_next, e_cr;
    logic [DIM_W-1:0] rq_reg, rq_next, e_rq;
    logic [RRW-1:0]   rr_reg, rr_next, e_rr;

    logic [CRW:0]     col_rsum;
    logic [RRW:0]     row_rsum;
    logic             col_carry;
    logic             row_carry;
    logic             emit;
    logic             col_end;
    logic             src_wrap;

    // A flagged pixel sees the counters as cleared.
    assign e_src_col = frame_start ? '0 : src_col_reg;
    assign e_src_row = frame_start ? '0 : src_row_reg;
    assign e_ocol    = frame_start ? '0 : ocol_reg;
    assign e_orow    = frame_start ? '0 : orow_reg;
    assign e_cq      = frame_start ? '0 : cq_reg;
    assign e_cr      = frame_start ? '0 : cr_reg;
    assign e_rq      = frame_start ? '0 : rq_reg;
    assign e_rr      = frame_start ? '0 : rr_reg;

    assign emit = (e_orow < ORW'(OUT_HEIGHT))
               && (DIM_W'(e_src_row) == e_rq)
               && (DIM_W'(e_src_col) == e_cq);

    assign col_end  = e_ocol == OCW'(OUT_WIDTH - 1);
    assign src_wrap = (DIM_W'(e_src_col) + DIM_W'(1)) >= src_w;

    assign col_rsum  = (CRW+1)'(e_cr) + (CRW+1)'(w_rem);
    assign col_carry = col_rsum >= (CRW+1)'(OUT_WIDTH);
    assign row_rsum  = (RRW+1)'(e_rr) + (RRW+1)'(h_rem);
    assign row_carry = row_rsum >= (RRW+1)'(OUT_HEIGHT);

    always_comb
    begin
        ocol_next = e_ocol;
        orow_next = e_orow;
        cq_next   = e_cq;
        cr_next   = e_cr;
        rq_next   = e_rq;
        rr_next   = e_rr;

        if (emit)
        begin
            if (col_end)
            begin
                ocol_next = '0;
                cq_next   = '0;
                cr_next   = '0;
                orow_next = e_orow + ORW'(1);
                // accumulate the row target as quotient and remainder
                if (row_carry)
                begin
                    rq_next = e_rq + h_quot + DIM_W'(1);
                    rr_next = RRW'(row_rsum - (RRW+1)'(OUT_HEIGHT));
                end
                else
                begin
                    rq_next = e_rq + h_quot;
                    rr_next = RRW'(row_rsum);
                end
            end
            else
            begin
                ocol_next = e_ocol + OCW'(1);
                if (col_carry)
                begin
                    cq_next = e_cq + w_quot + DIM_W'(1);
                    cr_next = CRW'(col_rsum - (CRW+1)'(OUT_WIDTH));
                end
                else
                begin
                    cq_next = e_cq + w_quot;
                    cr_next = CRW'(col_rsum);
                end
            end
        end

        if (src_wrap)
        begin
            src_col_next = '0;
            src_row_next = (e_src_row < CNT_W'(MAX_SOURCE_DIM - 1))
                         ? (e_src_row + CNT_W'(1)) : e_src_row;
        end
        else
        begin
            src_col_next = e_src_col + CNT_W'(1);
            src_row_next = e_src_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
            cq_reg      <= '0;
            cr_reg      <= '0;
            rq_reg      <= '0;
            rr_reg      <= '0;
        end
        else if (advance)
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            ocol_reg    <= ocol_next;
            orow_reg    <= orow_next;
            cq_reg      <= cq_next;
            cr_reg      <= cr_next;
            rq_reg      <= rq_next;
            rr_reg      <= rr_next;
        end
    end

    assign hit.emit   = emit;
    assign hit.last   = col_end && (e_orow == ORW'(OUT_HEIGHT - 1));
    assign hit.column = ndq_pkg::coord_t'(e_ocol);
    assign hit.line   = ndq_pkg::coord_t'(e_orow);

endmodule

// ===== rtl/ndq_quant.sv =====
// Int8 quantizer: Q16 gain, round half away from zero, zero point, saturation.
`timescale 1ns / 1ps

module ndq_quant (
    input  ndq_pkg::luma_t  luma,
    input  ndq_pkg::gain_t  gain,
    input  ndq_pkg::zp_t    quant_offset,
    output ndq_pkg::value_t value
);

    localparam int PROD_W = ndq_pkg::LUMA_W + ndq_pkg::GAIN_W;
    localparam int RND_W  = PROD_W - 15;
    localparam int SUM_W  = RND_W + 2;

    logic [ndq_pkg::LUMA_W-1:0] mag;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W:0]            prod_rnd;
    logic [RND_W-1:0]           rounded;
    logic                       neg;
    logic signed [SUM_W-1:0]    r_s;
    logic signed [SUM_W-1:0]    q_s;

    // |2y-255| is always odd: the upper seven bits are the lower seven bits of y, inverted when y is below 128.
    assign neg = ~luma[ndq_pkg::LUMA_W-1];
    assign mag = {neg ? ~luma[ndq_pkg::LUMA_W-2:0] : luma[ndq_pkg::LUMA_W-2:0], 1'b1};

    assign prod     = PROD_W'(mag) * PROD_W'(gain);
    assign prod_rnd = (PROD_W+1)'(prod) + (PROD_W+1)'(32768);
    assign rounded  = prod_rnd[PROD_W:16];
    assign r_s      = $signed({2'b00, rounded});
    assign q_s      = (neg ? -r_s : r_s) + SUM_W'(quant_offset);

    always_comb
    begin
        if (q_s > SUM_W'(127))
        begin
            value = ndq_pkg::value_t'(127);
        end
        else if (q_s < -SUM_W'(128))
        begin
            value = ndq_pkg::value_t'(-128);
        end
        else
        begin
            value = ndq_pkg::value_t'(q_s[ndq_pkg::VALUE_W-1:0]);
        end
    end

endmodule

// ===== rtl/nearest_downscale_quantize_unit.sv =====
// Top level of the nearest-neighbour downscaler with int8 quantizer.
`timescale 1ns / 1ps

// Takes one source luma byte per clock in raster order and keeps that rate as long as
// results are taken: each pixel passes an input register, the combinational coordinate
// match and quantization, and a result register. Pixels that do not land on the output
// grid produce nothing. The per-cycle work is set by the 8x24 gain multiplier of the
// quantizer and the quotient/remainder target compare of the scan logic. While a result
// waits on results, pixels off the grid keep flowing; the next selected pixel holds in
// the input register and stalls pixels until the waiting result is taken. The
// configuration channel is always ready; a size write is clamped and split into quotient
// and remainder by the output size as it is stored, and takes effect on the next target
// step.
module nearest_downscale_quantize_unit #(
    parameter int OUT_WIDTH      = ndq_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT     = ndq_pkg::OUT_HEIGHT_DEF,
    parameter int MAX_SOURCE_DIM = ndq_pkg::MAX_SOURCE_DIM_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ndq_pixel_if.sink      pixels,
    ndq_result_if.source   results,
    ndq_cfg_if.sink        cfg
);

    localparam int DIM_W = $clog2(MAX_SOURCE_DIM + 1);
    localparam int CRW   = $clog2(OUT_WIDTH);
    localparam int RRW   = $clog2(OUT_HEIGHT);

    logic [DIM_W-1:0]     src_w;
    logic [DIM_W-1:0]     w_quot;
    logic [CRW-1:0]       w_rem;
    logic [DIM_W-1:0]     h_quot;
    logic [RRW-1:0]       h_rem;
    ndq_pkg::gain_t       gain;
    ndq_pkg::zp_t         quant_offset;

    logic                 s1_valid_reg;
    ndq_pkg::luma_t       s1_luma_reg;
    logic                 s1_start_reg;

    logic                 res_valid_reg;
    ndq_pkg::value_t      res_value_reg;
    ndq_pkg::coord_t      res_column_reg;
    ndq_pkg::coord_t      res_line_reg;
    logic                 res_last_reg;

    ndq_pkg::coord_hit_t  hit;
    ndq_pkg::value_t      q_value;
    logic                 advance;
    logic                 in_take;

    ndq_cfg_regs #(
        .OUT_WIDTH      (OUT_WIDTH),
        .OUT_HEIGHT     (OUT_HEIGHT),
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .src_w        (src_w),
        .w_quot       (w_quot),
        .w_rem        (w_rem),
        .h_quot       (h_quot),
        .h_rem        (h_rem),
        .gain         (gain),
        .quant_offset (quant_offset)
    );

    ndq_scan #(
        .OUT_WIDTH      (OUT_WIDTH),
        .OUT_HEIGHT     (OUT_HEIGHT),
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .frame_start (s1_start_reg),
        .src_w       (src_w),
        .w_quot      (w_quot),
        .w_rem       (w_rem),
        .h_quot      (h_quot),
        .h_rem       (h_rem),
        .hit         (hit)
    );

    ndq_quant u_quant (
        .luma         (s1_luma_reg),
        .gain         (gain),
        .quant_offset (quant_offset),
        .value        (q_value)
    );

    // Hold the input register only when it carries a result and the output is stalled.
    assign advance      = s1_valid_reg && (!hit.emit || !res_valid_reg || results.ready);
    assign pixels.ready = !s1_valid_reg || advance;
    assign in_take      = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_luma_reg  <= pixels.luma;
            s1_start_reg <= pixels.frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && hit.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit.emit)
        begin
            res_value_reg  <= q_value;
            res_column_reg <= hit.column;
            res_line_reg   <= hit.line;
            res_last_reg   <= hit.last;
        end
    end

    assign results.valid       = res_valid_reg;
    assign results.pixel_value = res_value_reg;
    assign results.out_column  = res_column_reg;
    assign results.out_line    = res_line_reg;
    assign results.frame_last  = res_last_reg;

endmodule

// ===== rtl/ndq_checker.sv =====
// Port-level checker of the downscale quantize unit and its bind.
`timescale 1ns / 1ps
`include "nearest_downscale_quantize_unit_assert.svh"

module ndq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            res_valid,
    input logic            res_ready,
    input ndq_pkg::value_t res_value,
    input ndq_pkg::coord_t res_column,
    input ndq_pkg::coord_t res_line,
    input logic            res_last
);

    `NDQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_column) && $stable(res_line) && $stable(res_last), "result changed while stalled")
    `NDQ_ASSERT_IMPL(a_reset_quiet, $rose(rst_n), !res_valid, "result valid right after reset")
    `NDQ_ASSERT_IMPL(a_res_cause, !res_valid ##1 res_valid, $past(in_valid && in_ready, 2), "new result without a pixel transaction two cycles earlier")

endmodule

bind nearest_downscale_quantize_unit ndq_checker u_ndq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixels.valid),
    .in_ready   (pixels.ready),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_value  (results.pixel_value),
    .res_column (results.out_column),
    .res_line   (results.out_line),
    .res_last   (results.frame_last)
);
